@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define CHK_ALWAYS(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pce_pkg.sv @@
package pce_pkg;

    localparam int CORDIC_STEPS_DEF = 18;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int MAX_STEPS        = 30;
    localparam int T_WIDTH          = 19;
    localparam int COORD_WIDTH      = 32;
    localparam int RADIUS_WIDTH     = 31;
    localparam logic [T_WIDTH-1:0] T_LIMIT = 19'd411774;

    // Angles in Q2.30
    localparam logic signed [35:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [35:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [35:0] Q30_GAIN    = 36'sd652032874;

    typedef enum logic [1:0] {
        KIND_CIRCLE  = 2'd0,
        KIND_ELLIPSE = 2'd1,
        KIND_HELIX   = 2'd2,
        KIND_SPARE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_KIND     = 3'd0,
        REG_CENTER_X = 3'd1,
        REG_CENTER_Y = 3'd2,
        REG_CENTER_Z = 3'd3,
        REG_RADIUS_X = 3'd4,
        REG_RADIUS_Y = 3'd5,
        REG_STEP     = 3'd6,
        REG_NONE     = 3'd7
    } reg_idx_t;

    function automatic logic [31:0] atan_q30(input int i);
        case (i)
            0:  atan_q30 = 32'd843314857;
            1:  atan_q30 = 32'd497837829;
            2:  atan_q30 = 32'd263043837;
            3:  atan_q30 = 32'd133525159;
            4:  atan_q30 = 32'd67021687;
            5:  atan_q30 = 32'd33543516;
            6:  atan_q30 = 32'd16775851;
            7:  atan_q30 = 32'd8388437;
            8:  atan_q30 = 32'd4194283;
            9:  atan_q30 = 32'd2097149;
            default: atan_q30 = 32'd1 << (30 - i);
        endcase
    endfunction

    // Round half up of a Q30 constant to f fraction bits.
    function automatic logic signed [35:0] rnd_q30(input logic signed [35:0] v, input int f);
        logic signed [35:0] r;
        r = v;
        if (f < 30) begin
            r = (v + (36'sd1 <<< (29 - f))) >>> (30 - f);
        end
        return r;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/pce_cordic.sv @@
module pce_cordic import pce_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int W            = FRAC_BITS + 4
) (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [W-1:0] z_in,
    input  logic                flip_in,
    output logic signed [W-1:0] sin_out,
    output logic signed [W-1:0] cos_out
);

    logic signed [W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [W-1:0] z_reg [0:CORDIC_STEPS];
    logic                f_reg [0:CORDIC_STEPS];

    localparam logic signed [35:0] GAIN_R = rnd_q30(Q30_GAIN, FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0] <= GAIN_R[W-1:0];
            y_reg[0] <= '0;
            z_reg[0] <= z_in;
            f_reg[0] <= flip_in;
        end
    end

    // One micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
        localparam logic signed [35:0] DA =
            rnd_q30($signed({4'd0, atan_q30(i)}), FRAC_BITS);
        always_ff @(posedge aclk) begin
            if (en) begin
                f_reg[i+1] <= f_reg[i];
                if (!z_reg[i][W-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - DA[W-1:0];
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + DA[W-1:0];
                end
            end
        end
    end

    assign sin_out = f_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
    assign cos_out = f_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];

endmodule

@@ hw/rtl/parametric_curve_evaluator.sv @@
// Throughput: one transaction per cycle; the whole pipe advances when the output
// register is empty or being drained, so a stall holds every stage in place.
// Reset: aresetn is synchronous, active low; it clears the stage valid bits and
// all configuration registers to zero.
module parametric_curve_evaluator import pce_pkg::*; #(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Configuration write port
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // Input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // [18:0] param_t, rest zero
    input  logic         s_tuser,   // [0] func
    // Result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [0] valid_res, [32:1] coord_x, [64:33] coord_y,
                                    // [96:65] coord_z, rest zero
    output logic         m_tuser    // [0] func of the result (echo)
);

    localparam int W    = FRAC_BITS + 4;       // sine/cosine word, Q3.FRAC_BITS
    localparam int DEPTH = CORDIC_STEPS + 5;   // stage count incl. output reg

    // ---------------- configuration registers ----------------
    logic [1:0]         kind_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg, step_reg;
    logic [30:0]        rx_reg, ry_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_reg <= '0; cx_reg <= '0; cy_reg <= '0; cz_reg <= '0;
            rx_reg <= '0; ry_reg <= '0; step_reg <= '0;
        end else if (cfg_we) begin
            case (reg_idx_t'(cfg_index))
                REG_KIND:     kind_reg <= cfg_data[1:0];
                REG_CENTER_X: cx_reg   <= cfg_data;
                REG_CENTER_Y: cy_reg   <= cfg_data;
                REG_CENTER_Z: cz_reg   <= cfg_data;
                REG_RADIUS_X: rx_reg   <= cfg_data[30:0];
                REG_RADIUS_Y: ry_reg   <= cfg_data[30:0];
                REG_STEP:     step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective radii: other kinds use rx for both; an ellipse with a zero radius collapses both.
    logic [30:0] rx_eff, ry_eff;
    always_comb begin
        rx_eff = rx_reg;
        ry_eff = rx_reg;
        if (kind_t'(kind_reg) == KIND_ELLIPSE) begin
            ry_eff = ry_reg;
            if (rx_reg == '0 || ry_reg == '0) begin
                rx_eff = '0;
                ry_eff = '0;
            end
        end
    end

    // ---------------- pipeline control ----------------
    // Every stage advances together when the output register can take data.
    logic adv;
    logic [DEPTH-1:0] vld_reg;
    assign adv      = !vld_reg[DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_tvalid};
        end
    end

    // Side data that travels with each item: func, t, in-range flag.
    logic [T_WIDTH-1:0] t_pipe_reg [0:DEPTH-1];
    logic               fn_pipe_reg [0:DEPTH-1];
    logic               ok_pipe_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_pipe_reg[0]  <= s_tdata[T_WIDTH-1:0];
            fn_pipe_reg[0] <= s_tuser;
            ok_pipe_reg[0] <= s_tdata[T_WIDTH-1:0] <= T_LIMIT;
            for (int i = 1; i < DEPTH; i++) begin
                t_pipe_reg[i]  <= t_pipe_reg[i-1];
                fn_pipe_reg[i] <= fn_pipe_reg[i-1];
                ok_pipe_reg[i] <= ok_pipe_reg[i-1];
            end
        end
    end

    // ---------------- stage 1: angle fold ----------------
    // Take t to Q2.30, fold into -pi/2..pi/2, round to FRAC_BITS.
    logic signed [35:0]  a0, a1;
    logic                flip;
    logic signed [35:0]  z_r;
    always_comb begin
        a0   = $signed({3'd0, t_pipe_reg[0], 14'd0});
        flip = 1'b0;
        if (a0 > Q30_PI) begin
            a0 = a0 - Q30_TWO_PI;
        end
        a1 = a0;
        if (a0 > Q30_HALF_PI) begin
            a1   = a0 - Q30_PI;
            flip = 1'b1;
        end else if (a0 < -Q30_HALF_PI) begin
            a1   = a0 + Q30_PI;
            flip = 1'b1;
        end
        z_r = (a1 + (36'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    end

    // ---------------- CORDIC stages ----------------
    logic signed [W-1:0] sin_w, cos_w;
    pce_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .FRAC_BITS    (FRAC_BITS),
        .W            (W)
    ) u_cordic (
        .aclk    (aclk),
        .en      (adv),
        .z_in    (z_r[W-1:0]),
        .flip_in (flip),
        .sin_out (sin_w),
        .cos_out (cos_w)
    );

    // CORDIC output lines up with pipe index CORDIC_STEPS+1.
    localparam int PM = CORDIC_STEPS + 1;

    // ---------------- multiply stage ----------------
    // Radius (31b) by sine/cosine (W bits); step (32b) by t (19b).
    logic signed [63:0] prod_c_reg, prod_s_reg, prod_h_reg;
    logic signed [31:0] ryc_pre;
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_c_reg <= 64'($signed({1'b0, rx_eff}) * cos_w);
            prod_s_reg <= 64'($signed({1'b0, ry_eff}) * sin_w);
            prod_h_reg <= 64'(step_reg * $signed({1'b0, t_pipe_reg[PM]}));
        end
    end
    assign ryc_pre = '0;

    // Derivative needs rx*sin and ry*cos; a second pair of multipliers
    // computes them alongside the position products, with no selection by func.
    logic signed [63:0] pd_x_reg, pd_y_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            pd_x_reg <= 64'($signed({1'b0, rx_eff}) * sin_w);
            pd_y_reg <= 64'($signed({1'b0, ry_eff}) * cos_w);
        end
    end

    // ---------------- round stage ----------------
    localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);
    logic signed [63:0] rc_reg, rs_reg, rh_reg, rdx_reg, rdy_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            rc_reg  <= (prod_c_reg + HALF_F) >>> FRAC_BITS;
            rs_reg  <= (prod_s_reg + HALF_F) >>> FRAC_BITS;
            rh_reg  <= (prod_h_reg + 64'sd32768) >>> 16;
            rdx_reg <= (pd_x_reg + HALF_F) >>> FRAC_BITS;
            rdy_reg <= (pd_y_reg + HALF_F) >>> FRAC_BITS;
        end
    end

    // ---------------- sum, saturate and output register ----------------
    localparam int PO = DEPTH - 1;
    logic signed [31:0] ox, oy, oz;
    logic               helix;
    always_comb begin
        helix = (kind_t'(kind_reg) == KIND_HELIX);
        if (!fn_pipe_reg[PO-1]) begin
            ox = sat32(66'(cx_reg) + 66'(rc_reg));
            oy = sat32(66'(cy_reg) + 66'(rs_reg));
            oz = helix ? sat32(66'(cz_reg) + 66'(rh_reg)) : ryc_pre;
        end else begin
            ox = sat32(-66'(rdx_reg));
            oy = sat32(66'(rdy_reg));
            oz = helix ? step_reg : ryc_pre;
        end
        if (!ok_pipe_reg[PO-1]) begin
            ox = '0;
            oy = '0;
            oz = '0;
        end
    end

    logic [96:0] out_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= {oz, oy, ox, ok_pipe_reg[PO-1]};
        end
    end

    assign m_tdata = {7'd0, out_reg};
    assign m_tuser = fn_pipe_reg[PO];

endmodule

@@ hw/rtl/pce_checker.sv @@
`include "assert_macros.svh"
module pce_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata
);
    // Hold a stalled result.
    `CHK_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
              m_tvalid && $stable(m_tdata), "stalled result changed")
    // Accept input whenever the output is free.
    `CHK_ALWAYS(a_ready, aclk, aresetn, !m_tvalid |-> s_tready, "input blocked with empty output")
    // An out-of-range result carries zero coordinates.
    `CHK_ALWAYS(a_zero, aclk, aresetn, (m_tvalid && !m_tdata[0]) |-> (m_tdata[96:1] == '0),
                "out-of-range result nonzero")
    // Padding stays zero.
    `CHK_ALWAYS(a_pad, aclk, aresetn, m_tdata[103:97] == '0, "padding bits set")
endmodule

bind parametric_curve_evaluator pce_checker u_pce_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
